[sv/bphc_pkg.sv]
`timescale 1ns / 1ps

package bphc_pkg;

  // Field and register widths
  localparam int unsigned DebounceW = 8;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned RepeatW   = 8;
  localparam int unsigned EventW    = 2;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TdataW    = 8;

  typedef logic [EventW-1:0]   event_t;
  typedef logic [CfgAddrW-1:0] cfg_addr_t;

  // Event codes
  localparam event_t EV_NONE  = 2'd0;
  localparam event_t EV_PRESS = 2'd1;
  localparam event_t EV_SHORT = 2'd2;
  localparam event_t EV_LONG  = 2'd3;

  // Configuration register indexes
  localparam cfg_addr_t REG_DEBOUNCE = 2'd0;
  localparam cfg_addr_t REG_SHORT    = 2'd1;
  localparam cfg_addr_t REG_LONG     = 2'd2;
  localparam cfg_addr_t REG_REPEAT   = 2'd3;

  // Reset values of the registers
  localparam logic [DebounceW-1:0] DebounceRst = 8'd5;
  localparam logic [HoldW-1:0]     ShortRst    = 16'd50;
  localparam logic [HoldW-1:0]     LongRst     = 16'd200;
  localparam logic [RepeatW-1:0]   RepeatRst   = 8'd50;

  localparam logic [HoldW-1:0]     HoldMax     = '1;

endpackage

[sv/button_press_hold_classifier.sv]
`timescale 1ns / 1ps

// Button press and hold classifier.
// The input stream carries one sampled button level per request (in_tdata
// bit 0, 1 = pressed); the output stream returns exactly one event code per
// input request (out_tdata bits 1:0: none, press, short hold, long-hold
// repeat). Thresholds are set through the write-only cfg_ port, which
// should only be written while no request is in flight.
// An accepted request's event is registered into the output register, or
// into the skid entry while that register is held. Throughput is one
// request per cycle while in_tready is high; all counter updates are a single
// add and compare between the sample handshake and the two-entry buffer.
// The result side holds an output register plus one skid entry, so a new
// sample is still taken while one result waits; only when both entries are
// full does in_tready fall, and it rises again as soon as the receiver
// takes a result.
// Synchronous active-low reset restores the register defaults, reloads the
// counters, disarms the block and empties the result buffer. The first
// pressed sample after reset only arms the block.
module button_press_hold_classifier (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bphc_pkg::TdataW-1:0]  in_tdata,   // [0] pressed
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bphc_pkg::TdataW-1:0]  out_tdata,  // [1:0] event_code
  input  logic                         cfg_we,
  input  logic [bphc_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [bphc_pkg::CfgDataW-1:0] cfg_wdata
);
  import bphc_pkg::*;

  // Configuration registers
  logic [DebounceW-1:0] debounce_ticks_r;
  logic [HoldW-1:0]     short_hold_ticks_r;
  logic [HoldW-1:0]     long_hold_ticks_r;
  logic [RepeatW-1:0]   repeat_ticks_r;

  // Classifier state
  logic [DebounceW-1:0] debounce_left_r, debounce_left_nxt;
  logic [HoldW-1:0]     hold_count_r, hold_count_nxt;
  logic [RepeatW-1:0]   repeat_left_r, repeat_left_nxt;
  logic                 armed_r, armed_nxt;
  event_t               ev_nxt;

  // Result buffer: output register plus one skid entry
  logic   out_valid_r, skid_valid_r;
  event_t out_ev_r, skid_ev_r;

  logic in_acc, out_acc, pressed;
  logic [RepeatW-1:0] repeat_dec;

  assign pressed   = in_tdata[0];
  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_valid_r & out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TdataW - EventW){1'b0}}, out_ev_r};

  // Configuration writes; all four 2-bit indexes select a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DebounceRst;
      short_hold_ticks_r <= ShortRst;
      long_hold_ticks_r  <= LongRst;
      repeat_ticks_r     <= RepeatRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE: debounce_ticks_r   <= cfg_wdata[DebounceW-1:0];
        REG_SHORT:    short_hold_ticks_r <= cfg_wdata[HoldW-1:0];
        REG_LONG:     long_hold_ticks_r  <= cfg_wdata[HoldW-1:0];
        REG_REPEAT:   repeat_ticks_r     <= cfg_wdata[RepeatW-1:0];
        default: ;
      endcase
    end
  end

  assign repeat_dec = repeat_left_r - 1'b1;

  // Next state and event for the sample being accepted.
  always_comb begin
    debounce_left_nxt = debounce_left_r;
    hold_count_nxt    = hold_count_r;
    repeat_left_nxt   = repeat_left_r;
    armed_nxt         = armed_r;
    ev_nxt            = EV_NONE;
    if (pressed) begin
      if (!armed_r) begin
        armed_nxt = 1'b1;
      end else if (debounce_left_r != '0) begin
        debounce_left_nxt = debounce_left_r - 1'b1;
      end else if (hold_count_r <= long_hold_ticks_r) begin
        // Saturates at the top so a maximal long limit never repeats.
        if (hold_count_r != HoldMax) begin
          hold_count_nxt = hold_count_r + 1'b1;
        end
      end else begin
        // Repeat interval of zero wraps to a full 256-sample period.
        if (repeat_dec == '0) begin
          ev_nxt          = EV_LONG;
          repeat_left_nxt = repeat_ticks_r;
        end else begin
          repeat_left_nxt = repeat_dec;
        end
      end
    end else begin
      if (armed_r) begin
        if (hold_count_r >= short_hold_ticks_r && hold_count_r <= long_hold_ticks_r) begin
          ev_nxt = EV_SHORT;
        end else if (debounce_left_r == '0 && hold_count_r < short_hold_ticks_r) begin
          ev_nxt = EV_PRESS;
        end
      end
      debounce_left_nxt = debounce_ticks_r;
      hold_count_nxt    = '0;
      repeat_left_nxt   = repeat_ticks_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_left_r <= DebounceRst;
      hold_count_r    <= '0;
      repeat_left_r   <= RepeatRst;
      armed_r         <= 1'b0;
    end else if (in_acc) begin
      debounce_left_r <= debounce_left_nxt;
      hold_count_r    <= hold_count_nxt;
      repeat_left_r   <= repeat_left_nxt;
      armed_r         <= armed_nxt;
    end
  end

  // Two-entry result buffer. The skid entry only fills while the output
  // register is occupied and not being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_acc || !out_valid_r) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          out_ev_r     <= skid_ev_r;
          skid_valid_r <= in_acc;
          skid_ev_r    <= ev_nxt;
        end else begin
          out_valid_r <= in_acc;
          out_ev_r    <= ev_nxt;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
        skid_ev_r    <= ev_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // The skid entry is never occupied while the output register is empty.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // Once armed, the block stays armed until reset.
  a_armed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |=> armed_r)
    else $error("armed flag dropped");

  // A released sample reloads the hold counter.
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !pressed) |=> (hold_count_r == '0))
    else $error("hold count not cleared on release");

  // No event is produced before the block is armed.
  a_unarmed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !armed_r) |-> (ev_nxt == EV_NONE))
    else $error("event produced while not armed");

  // Long-hold repeats only occur past the long limit with debounce done.
  a_long_past_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ev_nxt == EV_LONG) |->
      (debounce_left_r == '0 && hold_count_r > long_hold_ticks_r))
    else $error("long-hold event before long limit");
`endif

endmodule
